// ----- hdl/cvx_pkg.sv -----
// Shared types and constants for the polygon convexity checker.
// No dependencies; every other file in this folder but cvx_checker imports this package.
package cvx_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CR_W    = PROD_W + 1;
    localparam int TOL_W   = 32;
    localparam int CMP_W   = (CR_W > TOL_W) ? CR_W : TOL_W;
    localparam int CNT_W   = 2;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(3);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CR_W-1:0]    cross_t;
    typedef logic [TOL_W-1:0]          tol_t;
    typedef logic [CNT_W-1:0]          count_t;

    typedef enum logic [1:0] {
        TURN_NONE  = 2'd0,
        TURN_RIGHT = 2'd1,
        TURN_LEFT  = 2'd2
    } turn_t;

    typedef struct packed {
        prod_t lhs;
        prod_t rhs;
    } cross_terms_t;

    typedef struct packed {
        turn_t seen;
        logic  mismatch;
    } turn_state_t;

endpackage

// ----- hdl/cvx_cross.sv -----
// Forms the two partial products of the cross product for one vertex triple.
// Depends on cvx_pkg.
module cvx_cross (
    input  cvx_pkg::coord_t       a_x,
    input  cvx_pkg::coord_t       a_y,
    input  cvx_pkg::coord_t       b_x,
    input  cvx_pkg::coord_t       b_y,
    input  cvx_pkg::coord_t       c_x,
    input  cvx_pkg::coord_t       c_y,
    output cvx_pkg::cross_terms_t terms
);
    import cvx_pkg::*;

    diff_t bax;
    diff_t cay;
    diff_t cax;
    diff_t bay;

    assign bax = DIFF_W'(b_x) - DIFF_W'(a_x);
    assign cay = DIFF_W'(c_y) - DIFF_W'(a_y);
    assign cax = DIFF_W'(c_x) - DIFF_W'(a_x);
    assign bay = DIFF_W'(b_y) - DIFF_W'(a_y);

    assign terms.lhs = PROD_W'(bax) * PROD_W'(cay);
    assign terms.rhs = PROD_W'(cax) * PROD_W'(bay);

endmodule

// ----- hdl/cvx_classify.sv -----
// Turns registered cross product terms into a turn direction using the tolerance.
// Depends on cvx_pkg.
module cvx_classify (
    input  cvx_pkg::cross_terms_t terms,
    input  cvx_pkg::tol_t         tolerance,
    output cvx_pkg::turn_t        turn
);
    import cvx_pkg::*;

    cross_t           cr;
    logic [CR_W-1:0]  mag;

    assign cr  = CR_W'(terms.lhs) - CR_W'(terms.rhs);
    assign mag = cr[CR_W-1] ? CR_W'(-cr) : CR_W'(cr);

    always_comb
    begin
        if (CMP_W'(mag) <= CMP_W'(tolerance))
        begin
            turn = TURN_NONE;
        end
        else if (cr[CR_W-1])
        begin
            turn = TURN_RIGHT;
        end
        else
        begin
            turn = TURN_LEFT;
        end
    end

endmodule

// ----- hdl/polygon_convexity_check.sv -----
// Top level of the polygon convexity checker: vertex registers, product stage,
// turn tracking and result register. Depends on cvx_pkg, cvx_cross, cvx_classify.
//
// Vertices arrive on the vertex channel (vertex_valid, vertex_stall, x_coord,
// y_coord, last_point); a transaction completes when vertex_valid is high and
// vertex_stall is low. One vertex can be taken in every cycle that is not stalled.
// Only a vertex with last_point set produces a result transaction on the result
// channel (result_valid, result_stall, is_convex, too_few_points).
// After the input register takes its last vertex, the result moves through the
// product register into the result register. The six multipliers of the product
// stage set the cycle. The tolerance is written through cfg_we and cfg_wdata;
// the user must do so only while the block is idle; the block does not enforce it.
// When the receiver stalls a waiting result, vertices keep flowing until the next
// last vertex reaches the product register; only then does vertex_stall rise, and
// it stays high until the waiting result is taken.
// Reset clears the tolerance, all valid flags and the polygon state, so the first
// vertex after reset starts a new polygon.
module polygon_convexity_check (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  cvx_pkg::tol_t   cfg_wdata,
    input  logic            vertex_valid,
    output logic            vertex_stall,
    input  cvx_pkg::coord_t x_coord,
    input  cvx_pkg::coord_t y_coord,
    input  logic            last_point,
    output logic            result_valid,
    input  logic            result_stall,
    output logic            is_convex,
    output logic            too_few_points
);
    import cvx_pkg::*;

    function automatic turn_state_t note_turn(turn_state_t s, turn_t t);
        turn_state_t r;
        r = s;
        if (t != TURN_NONE)
        begin
            if (s.seen == TURN_NONE)
            begin
                r.seen = t;
            end
            else if (s.seen != t)
            begin
                r.mismatch = 1'b1;
            end
        end
        return r;
    endfunction

    tol_t         tol_reg;
    logic         hold;

    logic         s0_valid_reg;
    coord_t       s0_x_reg;
    coord_t       s0_y_reg;
    logic         s0_last_reg;

    count_t       count_reg;
    coord_t       first_x_reg [2];
    coord_t       first_y_reg [2];
    coord_t       recent_x_reg [2];
    coord_t       recent_y_reg [2];
    logic         enough;

    cross_terms_t t1_terms;
    cross_terms_t t2_terms;
    cross_terms_t t3_terms;

    logic         s1_valid_reg;
    logic         s1_last_reg;
    logic         s1_enough_reg;
    cross_terms_t t1_reg;
    cross_terms_t t2_reg;
    cross_terms_t t3_reg;

    turn_t        t1_turn;
    turn_t        t2_turn;
    turn_t        t3_turn;
    turn_state_t  turn_reg;
    turn_state_t  turn_next;

    logic         result_valid_reg;
    logic         is_convex_reg;
    logic         too_few_reg;

    assign hold = s1_valid_reg && s1_last_reg && result_valid_reg && result_stall;
    assign vertex_stall = hold;
    assign enough = (count_reg >= 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            s0_valid_reg <= vertex_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold && vertex_valid)
        begin
            s0_x_reg    <= x_coord;
            s0_y_reg    <= y_coord;
            s0_last_reg <= last_point;
        end
    end

    cvx_cross u_cross_inner (
        .a_x   (recent_x_reg[0]),
        .a_y   (recent_y_reg[0]),
        .b_x   (recent_x_reg[1]),
        .b_y   (recent_y_reg[1]),
        .c_x   (s0_x_reg),
        .c_y   (s0_y_reg),
        .terms (t1_terms)
    );

    cvx_cross u_cross_close (
        .a_x   (recent_x_reg[1]),
        .a_y   (recent_y_reg[1]),
        .b_x   (s0_x_reg),
        .b_y   (s0_y_reg),
        .c_x   (first_x_reg[0]),
        .c_y   (first_y_reg[0]),
        .terms (t2_terms)
    );

    cvx_cross u_cross_wrap (
        .a_x   (s0_x_reg),
        .a_y   (s0_y_reg),
        .b_x   (first_x_reg[0]),
        .b_y   (first_y_reg[0]),
        .c_x   (first_x_reg[1]),
        .c_y   (first_y_reg[1]),
        .terms (t3_terms)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (s0_valid_reg && !hold)
        begin
            if (s0_last_reg)
            begin
                count_reg <= '0;
            end
            else if (count_reg != CNT_FULL)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_valid_reg && !hold)
        begin
            if (!count_reg[1])
            begin
                first_x_reg[count_reg[0]] <= s0_x_reg;
                first_y_reg[count_reg[0]] <= s0_y_reg;
            end
            recent_x_reg[0] <= recent_x_reg[1];
            recent_y_reg[0] <= recent_y_reg[1];
            recent_x_reg[1] <= s0_x_reg;
            recent_y_reg[1] <= s0_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_valid_reg && !hold)
        begin
            s1_last_reg   <= s0_last_reg;
            s1_enough_reg <= enough;
            t1_reg        <= t1_terms;
            t2_reg        <= t2_terms;
            t3_reg        <= t3_terms;
        end
    end

    cvx_classify u_class_inner (
        .terms     (t1_reg),
        .tolerance (tol_reg),
        .turn      (t1_turn)
    );

    cvx_classify u_class_close (
        .terms     (t2_reg),
        .tolerance (tol_reg),
        .turn      (t2_turn)
    );

    cvx_classify u_class_wrap (
        .terms     (t3_reg),
        .tolerance (tol_reg),
        .turn      (t3_turn)
    );

    always_comb
    begin
        turn_next = turn_reg;
        if (s1_enough_reg)
        begin
            turn_next = note_turn(turn_next, t1_turn);
            if (s1_last_reg)
            begin
                turn_next = note_turn(turn_next, t2_turn);
                turn_next = note_turn(turn_next, t3_turn);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_reg <= '{seen: TURN_NONE, mismatch: 1'b0};
        end
        else if (s1_valid_reg && !hold)
        begin
            if (s1_last_reg)
            begin
                turn_reg <= '{seen: TURN_NONE, mismatch: 1'b0};
            end
            else
            begin
                turn_reg <= turn_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_last_reg && !hold)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_last_reg && !hold)
        begin
            is_convex_reg <= s1_enough_reg && !turn_next.mismatch;
            too_few_reg   <= !s1_enough_reg;
        end
    end

    assign result_valid   = result_valid_reg;
    assign is_convex      = is_convex_reg;
    assign too_few_points = too_few_reg;

endmodule

// ----- hdl/cvx_checker.sv -----
// Port-level checks for the polygon convexity checker, bound to its top level.
// Depends on polygon_convexity_check.
module cvx_checker (
    input logic clk,
    input logic rst_n,
    input logic vertex_valid,
    input logic vertex_stall,
    input logic result_valid,
    input logic result_stall,
    input logic is_convex,
    input logic too_few_points
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(is_convex) && $stable(too_few_points))
        else $error("A stalled result transaction changed or vanished.");

    a_short_not_convex: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(too_few_points && is_convex))
        else $error("A polygon with too few points was reported convex.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_stall |-> result_valid && result_stall)
        else $error("Vertex channel stalled without a stalled result.");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_stall |=> result_valid)
        else $error("Result dropped while the vertex channel was stalled.");

endmodule

bind polygon_convexity_check cvx_checker u_cvx_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .vertex_valid   (vertex_valid),
    .vertex_stall   (vertex_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .is_convex      (is_convex),
    .too_few_points (too_few_points)
);

// ----- verif/tb_polygon_convexity_check.sv -----
// Self-checking testbench for polygon_convexity_check. A scoreboard class predicts the
// verdict of each polygon from the accepted vertex transactions and checks every result.
// Depends on cvx_pkg and the polygon_convexity_check RTL with cvx_cross and cvx_classify.
`timescale 1ns / 100ps

module tb_polygon_convexity_check;
    import cvx_pkg::*;

    localparam int  QUIET_LIMIT   = 2000;
    localparam int  HOLD_CYCLES   = 80;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  PHASE_ITEMS   = 100;
    localparam real PI            = 3.14159265358979;

    typedef struct packed {
        logic convex;
        logic too_few;
    } verdict_t;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    class convexity_scoreboard;
        tol_t     tolerance;
        coord_t   first_x[2];
        coord_t   first_y[2];
        coord_t   prev_x[2];
        coord_t   prev_y[2];
        count_t   n_pts;
        turn_t    turn;
        logic     disagree;
        verdict_t verdicts_due[$];
        int       errors;
        int       n_vertices;
        int       n_verdicts;
        int       n_convex;
        int       n_concave;
        int       n_short;

        function new();
            tolerance = '0;
            n_pts = '0;
            turn = TURN_NONE;
            disagree = 1'b0;
            errors = 0;
            n_vertices = 0;
            n_verdicts = 0;
            n_convex = 0;
            n_concave = 0;
            n_short = 0;
        endfunction

        function turn_t classify(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                 coord_t cx, coord_t cy);
            longint cr_val;
            longint mag;
            cr_val = (longint'(bx) - longint'(ax)) * (longint'(cy) - longint'(ay))
                   - (longint'(cx) - longint'(ax)) * (longint'(by) - longint'(ay));
            mag = (cr_val < 0) ? -cr_val : cr_val;
            if (mag <= longint'({32'd0, tolerance}))
                return TURN_NONE;
            return (cr_val < 0) ? TURN_RIGHT : TURN_LEFT;
        endfunction

        function void record_turn(turn_t t);
            if (t == TURN_NONE)
                return;
            if (turn == TURN_NONE)
                turn = t;
            else if (turn != t)
                disagree = 1'b1;
        endfunction

        function void note_vertex(coord_t x, coord_t y, logic last);
            verdict_t v;
            n_vertices++;
            if (n_pts >= 2)
                record_turn(classify(prev_x[0], prev_y[0], prev_x[1], prev_y[1], x, y));
            if (n_pts < 2)
            begin
                first_x[n_pts] = x;
                first_y[n_pts] = y;
            end
            prev_x[0] = prev_x[1];
            prev_y[0] = prev_y[1];
            prev_x[1] = x;
            prev_y[1] = y;
            if (n_pts != CNT_FULL)
                n_pts++;
            if (!last)
                return;
            if (n_pts != CNT_FULL)
            begin
                v.convex = 1'b0;
                v.too_few = 1'b1;
                n_short++;
            end
            else
            begin
                record_turn(classify(prev_x[0], prev_y[0], x, y, first_x[0], first_y[0]));
                record_turn(classify(x, y, first_x[0], first_y[0], first_x[1], first_y[1]));
                v.convex = !disagree;
                v.too_few = 1'b0;
                if (v.convex)
                    n_convex++;
                else
                    n_concave++;
            end
            verdicts_due.push_back(v);
            n_pts = '0;
            turn = TURN_NONE;
            disagree = 1'b0;
        endfunction

        function void check_verdict(logic convex, logic too_few);
            verdict_t v;
            n_verdicts++;
            if (verdicts_due.size() == 0)
            begin
                $error("Result transaction arrived with no polygon verdict pending.");
                errors++;
                return;
            end
            v = verdicts_due.pop_front();
            if (convex !== v.convex)
            begin
                $error("is_convex mismatch: expected %0b, actual %0b", v.convex, convex);
                errors++;
            end
            if (too_few !== v.too_few)
            begin
                $error("too_few_points mismatch: expected %0b, actual %0b", v.too_few, too_few);
                errors++;
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    tol_t   cfg_wdata;
    logic   vertex_valid;
    logic   vertex_stall;
    coord_t x_coord;
    coord_t y_coord;
    logic   last_point;
    logic   result_valid;
    logic   result_stall;
    logic   is_convex;
    logic   too_few_points;

    convexity_scoreboard sb = new();
    coord_t poly_x[$];
    coord_t poly_y[$];
    int     burst_left = 0;
    bit     gaps_on = 1'b1;
    bit     hold_req = 1'b0;
    int     random_items = 0;
    int     tol_settings = 0;

    polygon_convexity_check dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .vertex_valid   (vertex_valid),
        .vertex_stall   (vertex_stall),
        .x_coord        (x_coord),
        .y_coord        (y_coord),
        .last_point     (last_point),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .is_convex      (is_convex),
        .too_few_points (too_few_points)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && vertex_valid && !vertex_stall)
            sb.note_vertex(x_coord, y_coord, last_point);
        if (rst_n && result_valid && !result_stall)
            sb.check_verdict(is_convex, too_few_points);
    end

    initial
    begin : result_backpressure
        int          hold_left;
        int          seg_left;
        int          tick;
        stall_mode_t mode;
        logic        stall_next;
        hold_left = 0;
        seg_left = 0;
        tick = 0;
        mode = STALL_NONE;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                stall_next = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(8, 64);
                    mode = stall_mode_t'($urandom_range(0, 3));
                end
                seg_left--;
                case (mode)
                    STALL_NONE:  stall_next = 1'b0;
                    STALL_COIN:  stall_next = ($urandom_range(0, 1) == 0);
                    STALL_HEAVY: stall_next = ($urandom_range(0, 9) < 7);
                    default:     stall_next = ((tick % 5) < 2);
                endcase
            end
            result_stall <= stall_next;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((vertex_valid && !vertex_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("No transaction for %0d cycles; %0d verdicts still pending.",
                 QUIET_LIMIT, sb.pending());
        $display("polygon_convexity_check verification failed");
        $finish;
    end

    task automatic put_vertex(input coord_t x, input coord_t y, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                vertex_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        vertex_valid <= 1'b1;
        x_coord <= x;
        y_coord <= y;
        last_point <= last;
        do
            @(posedge clk);
        while (vertex_stall);
    endtask

    task automatic add_point(input int x, input int y);
        poly_x.push_back(coord_t'(x));
        poly_y.push_back(coord_t'(y));
    endtask

    task automatic send_polygon();
        for (int i = 0; i < poly_x.size(); i++)
            put_vertex(poly_x[i], poly_y[i], i == poly_x.size() - 1);
        poly_x.delete();
        poly_y.delete();
    endtask

    task automatic settle();
        @(negedge clk);
        vertex_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tolerance(input tol_t value);
        settle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.tolerance = value;
        tol_settings++;
    endtask

    // Points on a circle in order; a dented polygon pulls one vertex toward the center.
    task automatic make_regular(input int n, input bit dent);
        int  r;
        int  m;
        int  cx;
        int  cy;
        int  dir;
        int  pick;
        real phase;
        real a;
        real rr;
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 40) : $urandom_range(40, 16000);
        m = 32767 - r;
        cx = int'($urandom_range(0, 2 * m)) - m;
        cy = int'($urandom_range(0, 2 * m)) - m;
        dir = $urandom_range(0, 1) ? 1 : -1;
        phase = $urandom_range(0, 359) * PI / 180.0;
        pick = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            a = phase + dir * 2.0 * PI * i / n;
            rr = (dent && i == pick) ? r * 0.25 : r;
            add_point(int'(cx + rr * $cos(a)), int'(cy + rr * $sin(a)));
        end
    endtask

    task automatic make_scatter(input int n, input int span);
        for (int i = 0; i < n; i++)
        begin
            if (span == 0)
                add_point(int'($urandom), int'($urandom));
            else
                add_point(int'($urandom_range(0, 2 * span)) - span,
                          int'($urandom_range(0, 2 * span)) - span);
        end
    endtask

    task automatic make_line(input int n);
        int x0;
        int y0;
        int dx;
        int dy;
        x0 = int'($urandom_range(0, 2000)) - 1000;
        y0 = int'($urandom_range(0, 2000)) - 1000;
        dx = int'($urandom_range(0, 600)) - 300;
        dy = int'($urandom_range(0, 600)) - 300;
        for (int i = 0; i < n; i++)
            add_point(x0 + i * dx, y0 + i * dy);
    endtask

    task automatic random_polygon();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 50)
            make_regular($urandom_range(3, 10), 1'b0);
        else if (kind < 65)
            make_regular($urandom_range(4, 10), 1'b1);
        else if (kind < 77)
            make_scatter($urandom_range(1, 8), 6);
        else if (kind < 85)
            make_scatter($urandom_range(3, 7), 0);
        else if (kind < 93)
            make_line($urandom_range(3, 8));
        else
            make_scatter($urandom_range(1, 2), 0);
        random_items += poly_x.size();
        send_polygon();
    endtask

    task automatic run_phase(input tol_t tol, input bit gaps, input bit squeeze);
        int start;
        bit paused;
        write_tolerance(tol);
        gaps_on = gaps;
        start = random_items;
        paused = 1'b0;
        if (squeeze)
        begin
            hold_req = 1'b1;
            repeat (10)
            begin
                make_regular(3, 1'b0);
                random_items += poly_x.size();
                send_polygon();
            end
        end
        while (random_items - start < PHASE_ITEMS)
        begin
            random_polygon();
            if (!paused && random_items - start >= PHASE_ITEMS / 2)
            begin
                settle();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        vertex_valid = 1'b0;
        x_coord = '0;
        y_coord = '0;
        last_point = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed polygons, checked against the reset tolerance of zero.
        add_point(32767, -32768);
        send_polygon();
        add_point(-32768, 32767);
        add_point(0, 0);
        send_polygon();
        add_point(-32768, -32768);
        add_point(32767, -32768);
        add_point(32767, 32767);
        send_polygon();
        add_point(0, 0);
        add_point(0, 100);
        add_point(100, 0);
        send_polygon();
        add_point(-5, -5);
        add_point(0, 0);
        add_point(5, 5);
        send_polygon();
        add_point(0, 0);
        add_point(40, 0);
        add_point(10, 10);
        add_point(0, 40);
        send_polygon();
        add_point(0, 0);
        add_point(50, 0);
        add_point(100, 0);
        add_point(100, 100);
        add_point(0, 100);
        send_polygon();
        // Only the closing triple centred on the last vertex turns the wrong way here.
        add_point(0, 0);
        add_point(10, 0);
        add_point(10, 10);
        add_point(5, 2);
        send_polygon();

        run_phase(tol_t'($urandom_range(0, 64)), 1'b1, 1'b0);
        run_phase(32'hFFFF_FFFF, 1'b1, 1'b0);
        run_phase(tol_t'($urandom), 1'b1, 1'b0);
        run_phase(32'd0, 1'b0, 1'b1);
        run_phase(tol_t'($urandom_range(0, 100000)), 1'b1, 1'b0);

        settle();
        $display("Run covered %0d vertices and %0d verdicts (%0d convex, %0d concave, %0d short)",
                 sb.n_vertices, sb.n_verdicts, sb.n_convex, sb.n_concave, sb.n_short);
        $display("across %0d tolerance settings, with a long result hold-off and drain pauses.",
                 tol_settings);
        if (sb.errors == 0)
            $display("polygon_convexity_check verification clean");
        else
            $display("polygon_convexity_check verification failed");
        $finish;
    end

endmodule
